FILE: rtl/lsts_pkg.sv
// Shared constants, types and codes for the per-source latency statistics table.
`default_nettype none

package lsts_pkg;

   localparam int MAX_PRODUCERS = 16;
   localparam int IDX_BITS      = $clog2(MAX_PRODUCERS);
   localparam int LIMIT_BITS    = 5;
   localparam int COUNT_BITS    = 24;
   localparam int DELAY_BITS    = 24;
   localparam int SUM_BITS      = COUNT_BITS + DELAY_BITS;
   localparam int KIND_BITS     = 2;
   localparam int STEP_BITS     = $clog2(DELAY_BITS + 1);

   localparam logic [KIND_BITS-1:0] KIND_MADE  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_EATEN = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_READ  = 2'd2;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_ACTIVE_PRODUCERS = 1'b0;
   localparam logic [LIMIT_BITS-1:0] ACTIVE_RESET = 5'd16;

   typedef struct packed {
      logic [COUNT_BITS-1:0] made;
      logic [COUNT_BITS-1:0] eaten;
      logic [DELAY_BITS-1:0] min_d;
      logic [DELAY_BITS-1:0] max_d;
      logic [SUM_BITS-1:0]   sum;
   } entry_type;

   typedef struct packed {
      logic                  start;
      logic [SUM_BITS-1:0]   dividend;
      logic [COUNT_BITS-1:0] divisor;
   } div_req_type;

endpackage

`default_nettype wire

FILE: rtl/lsts_table.sv
// Per-producer statistics memory with valid bits and registered read.
`default_nettype none

module lsts_table (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             rd_en,
   input  wire  [lsts_pkg::IDX_BITS-1:0]   rd_idx,
   output lsts_pkg::entry_type             rd_entry,
   input  wire                             wr_en,
   input  wire  [lsts_pkg::IDX_BITS-1:0]   wr_idx,
   input  lsts_pkg::entry_type             wr_entry
);

   lsts_pkg::entry_type                    entry_mem_ff [lsts_pkg::MAX_PRODUCERS];
   lsts_pkg::entry_type                    rd_data_ff;
   logic [lsts_pkg::MAX_PRODUCERS-1:0]     valid_ff;
   logic                                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_idx] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

FILE: rtl/lsts_div.sv
// Bit-serial restoring divider for the mean delay, one quotient bit per cycle.
`default_nettype none

module lsts_div (
   input  wire                              clock,
   input  wire                              reset,
   input  lsts_pkg::div_req_type            req,
   output logic                             done,
   output logic [lsts_pkg::DELAY_BITS-1:0]  quotient
);

   localparam logic [lsts_pkg::STEP_BITS-1:0] STEP_LAST =
      lsts_pkg::STEP_BITS'(lsts_pkg::DELAY_BITS - 1);

   logic [lsts_pkg::COUNT_BITS-1:0] rem_ff, rem_in;
   logic [lsts_pkg::DELAY_BITS-1:0] shift_ff, shift_in;
   logic [lsts_pkg::COUNT_BITS-1:0] divisor_ff, divisor_in;
   logic [lsts_pkg::STEP_BITS-1:0]  cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [lsts_pkg::COUNT_BITS:0]   trial;
   logic [lsts_pkg::COUNT_BITS:0]   diff;
   logic                            take;

   assign trial = {rem_ff, shift_ff[lsts_pkg::DELAY_BITS-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign take  = trial >= {1'b0, divisor_ff};

   always_comb begin
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (req.start) begin
         rem_in     = req.dividend[lsts_pkg::SUM_BITS-1:lsts_pkg::DELAY_BITS];
         shift_in   = req.dividend[lsts_pkg::DELAY_BITS-1:0];
         divisor_in = req.divisor;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in   = take ? diff[lsts_pkg::COUNT_BITS-1:0] : trial[lsts_pkg::COUNT_BITS-1:0];
         shift_in = {shift_ff[lsts_pkg::DELAY_BITS-2:0], take};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

`default_nettype wire

FILE: rtl/per_source_latency_stats_table_top.sv
// Per-source latency statistics table: control, update logic, CSR and result register.
//
// Each transaction passes from acceptance to result as follows. The entry is read from the
// table memory at the accepting edge, the update state updates it, writes it back and starts
// the divider, the bit-serial divider forms the mean delay, the divide state sees the divider
// finish and the output state loads the result register. One transaction is in flight at a
// time: a new one is accepted only in the idle state, after the result register is loaded.
// A new one is accepted while the previous result still waits on rsp_stall, and rsp_stall
// only lengthens the output state. req_stall is high during reset. The table clears at
// reset through per-entry valid bits, so no clearing pass is needed.
// active_producers lives at byte address 0.
`default_nettype none

module per_source_latency_stats_table_top (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [lsts_pkg::KIND_BITS-1:0]       req_type,
   input  wire  [lsts_pkg::IDX_BITS-1:0]        req_producer_index,
   input  wire  [lsts_pkg::DELAY_BITS-1:0]      req_delay_ms,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [lsts_pkg::IDX_BITS-1:0]        rsp_entry_index,
   output logic [lsts_pkg::COUNT_BITS-1:0]      rsp_made_count,
   output logic [lsts_pkg::COUNT_BITS-1:0]      rsp_eaten_count,
   output logic [lsts_pkg::DELAY_BITS-1:0]      rsp_shortest_delay,
   output logic [lsts_pkg::DELAY_BITS-1:0]      rsp_mean_delay,
   output logic [lsts_pkg::DELAY_BITS-1:0]      rsp_longest_delay,
   output logic                                 rsp_entry_mismatch,
   output logic                                 rsp_any_mismatch,
   output logic                                 rsp_bad_index,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [lsts_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire  [lsts_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [lsts_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_UPD  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]                          state_ff, state_in;
   logic [lsts_pkg::LIMIT_BITS-1:0]     active_ff;
   logic [lsts_pkg::KIND_BITS-1:0]      kind_ff;
   logic [lsts_pkg::IDX_BITS-1:0]       idx_ff;
   logic [lsts_pkg::DELAY_BITS-1:0]     delay_ff;
   logic                                bad_ff;
   logic [lsts_pkg::MAX_PRODUCERS-1:0]  flags_ff, flags_in;
   lsts_pkg::entry_type                 upd_ff;
   lsts_pkg::entry_type                 cur_entry;
   lsts_pkg::entry_type                 new_entry;
   lsts_pkg::div_req_type               div_req;
   logic                                div_done;
   logic [lsts_pkg::DELAY_BITS-1:0]     div_quotient;
   logic [lsts_pkg::MAX_PRODUCERS-1:0]  active_mask;
   logic                                req_accept;
   logic                                csr_write;
   logic                                mem_we;
   logic                                slot_free;
   logic                                rsp_load;
   logic                                zero_stats;

   logic                                rsp_valid_ff;
   logic [lsts_pkg::IDX_BITS-1:0]       rsp_entry_index_ff;
   logic [lsts_pkg::COUNT_BITS-1:0]     rsp_made_count_ff;
   logic [lsts_pkg::COUNT_BITS-1:0]     rsp_eaten_count_ff;
   logic [lsts_pkg::DELAY_BITS-1:0]     rsp_shortest_delay_ff;
   logic [lsts_pkg::DELAY_BITS-1:0]     rsp_mean_delay_ff;
   logic [lsts_pkg::DELAY_BITS-1:0]     rsp_longest_delay_ff;
   logic                                rsp_entry_mismatch_ff;
   logic                                rsp_any_mismatch_ff;
   logic                                rsp_bad_index_ff;

   // CSR
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == lsts_pkg::REG_ACTIVE_PRODUCERS);
   assign csr_prdata = (csr_paddr[2] == lsts_pkg::REG_ACTIVE_PRODUCERS)
                       ? {{(lsts_pkg::CSR_DATA_BITS - lsts_pkg::LIMIT_BITS){1'b0}}, active_ff}
                       : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= lsts_pkg::ACTIVE_RESET;
      end else if (csr_write) begin
         active_ff <= csr_pwdata[lsts_pkg::LIMIT_BITS-1:0];
      end
   end

   // control
   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = (state_ff == ST_OUT) && slot_free;
   assign mem_we     = (state_ff == ST_UPD) && !bad_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_accept) state_in = ST_UPD;
         ST_UPD:  state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_OUT;
         ST_OUT:  if (slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff  <= req_type;
         idx_ff   <= req_producer_index;
         delay_ff <= req_delay_ms;
         bad_ff   <= ({1'b0, req_producer_index} >= active_ff);
      end
   end

   lsts_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_idx   (req_producer_index),
      .rd_entry (cur_entry),
      .wr_en    (mem_we),
      .wr_idx   (idx_ff),
      .wr_entry (new_entry)
   );

   // entry update
   always_comb begin
      new_entry = cur_entry;
      unique case (kind_ff)
         lsts_pkg::KIND_MADE: begin
            if (cur_entry.made != '1) begin
               new_entry.made = cur_entry.made + 1'b1;
            end
         end
         lsts_pkg::KIND_EATEN: begin
            if (cur_entry.eaten == '0) begin
               new_entry.min_d = delay_ff;
               new_entry.max_d = delay_ff;
            end else begin
               if (delay_ff > cur_entry.max_d) new_entry.max_d = delay_ff;
               if (delay_ff < cur_entry.min_d) new_entry.min_d = delay_ff;
            end
            if (cur_entry.eaten != '1) begin
               new_entry.eaten = cur_entry.eaten + 1'b1;
               new_entry.sum   = cur_entry.sum
                                 + {{lsts_pkg::COUNT_BITS{1'b0}}, delay_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      flags_in = flags_ff;
      if (mem_we) begin
         flags_in[idx_ff] = (new_entry.made != new_entry.eaten);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPD) begin
         upd_ff <= new_entry;
      end
   end

   assign div_req.start    = (state_ff == ST_UPD);
   assign div_req.dividend = new_entry.sum;
   assign div_req.divisor  = new_entry.eaten;

   lsts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // result
   always_comb begin
      for (int i = 0; i < lsts_pkg::MAX_PRODUCERS; i++) begin
         active_mask[i] = (lsts_pkg::LIMIT_BITS'(i) < active_ff);
      end
   end

   assign zero_stats = bad_ff || (upd_ff.eaten == '0);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_entry_index_ff    <= idx_ff;
         rsp_made_count_ff     <= bad_ff ? '0 : upd_ff.made;
         rsp_eaten_count_ff    <= bad_ff ? '0 : upd_ff.eaten;
         rsp_shortest_delay_ff <= zero_stats ? '0 : upd_ff.min_d;
         rsp_mean_delay_ff     <= zero_stats ? '0 : div_quotient;
         rsp_longest_delay_ff  <= zero_stats ? '0 : upd_ff.max_d;
         rsp_entry_mismatch_ff <= !bad_ff && (upd_ff.made != upd_ff.eaten);
         rsp_any_mismatch_ff   <= |(flags_ff & active_mask);
         rsp_bad_index_ff      <= bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_index    = rsp_entry_index_ff;
   assign rsp_made_count     = rsp_made_count_ff;
   assign rsp_eaten_count    = rsp_eaten_count_ff;
   assign rsp_shortest_delay = rsp_shortest_delay_ff;
   assign rsp_mean_delay     = rsp_mean_delay_ff;
   assign rsp_longest_delay  = rsp_longest_delay_ff;
   assign rsp_entry_mismatch = rsp_entry_mismatch_ff;
   assign rsp_any_mismatch   = rsp_any_mismatch_ff;
   assign rsp_bad_index      = rsp_bad_index_ff;

`ifndef SYNTHESIS
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide phase");

   a_entry_mismatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_index |->
         rsp_entry_mismatch == (rsp_made_count != rsp_eaten_count))
      else $error("entry mismatch flag disagrees with counts");

   a_any_covers_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_mismatch |-> rsp_any_mismatch)
      else $error("any mismatch missing while entry mismatches");

   a_mean_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_eaten_count != '0 |->
         rsp_shortest_delay <= rsp_mean_delay && rsp_mean_delay <= rsp_longest_delay)
      else $error("mean delay outside min/max");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Testbench for per_source_latency_stats_table_top: random and directed traffic with a scoreboard.
`timescale 1ns / 100ps

module tb;
   import lsts_pkg::*;

   localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 2'd3;
   localparam logic [CSR_ADDR_BITS-1:0] ACTIVE_ADDR =
      CSR_ADDR_BITS'(4 * int'(REG_ACTIVE_PRODUCERS));
   localparam int RESULT_LATENCY = 40;
   localparam int IDLE_LIMIT     = 5000;
   localparam int RANDOM_ITEMS   = 1250;
   localparam int PHASE_ITEMS    = 250;

   typedef struct {
      logic [IDX_BITS-1:0]   entry_index;
      logic [COUNT_BITS-1:0] made_count;
      logic [COUNT_BITS-1:0] eaten_count;
      logic [DELAY_BITS-1:0] shortest_delay;
      logic [DELAY_BITS-1:0] mean_delay;
      logic [DELAY_BITS-1:0] longest_delay;
      logic                  entry_mismatch;
      logic                  any_mismatch;
      logic                  bad_index;
   } stats_report_type;

   class latency_stats_scoreboard;
      bit [COUNT_BITS-1:0] made_cnt  [MAX_PRODUCERS];
      bit [COUNT_BITS-1:0] eaten_cnt [MAX_PRODUCERS];
      bit [DELAY_BITS-1:0] min_dly   [MAX_PRODUCERS];
      bit [DELAY_BITS-1:0] max_dly   [MAX_PRODUCERS];
      bit [SUM_BITS-1:0]   dly_sum   [MAX_PRODUCERS];
      bit [LIMIT_BITS-1:0] active_producers;
      stats_report_type    expected_reports[$];
      int                  errors;

      function new();
         foreach (made_cnt[i]) begin
            made_cnt[i]  = '0;
            eaten_cnt[i] = '0;
            min_dly[i]   = '0;
            max_dly[i]   = '0;
            dly_sum[i]   = '0;
         end
         active_producers = ACTIVE_RESET;
         errors = 0;
      endfunction

      function void set_active(bit [LIMIT_BITS-1:0] value);
         active_producers = value;
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      function void record_request(bit [KIND_BITS-1:0] kind, bit [IDX_BITS-1:0] idx,
                                   bit [DELAY_BITS-1:0] delay);
         stats_report_type r;
         int              lim;
         int              unequal;
         bit              bad;
         bit [SUM_BITS:0] s;
         bit [SUM_BITS-1:0] q;
         lim = (active_producers < MAX_PRODUCERS) ? active_producers : MAX_PRODUCERS;
         bad = idx >= lim;
         if (!bad) begin
            if (kind == KIND_MADE) begin
               if (made_cnt[idx] != {COUNT_BITS{1'b1}}) made_cnt[idx]++;
            end else if (kind == KIND_EATEN) begin
               if (eaten_cnt[idx] == 0) begin
                  min_dly[idx] = delay;
                  max_dly[idx] = delay;
               end else begin
                  if (delay > max_dly[idx]) max_dly[idx] = delay;
                  if (delay < min_dly[idx]) min_dly[idx] = delay;
               end
               if (eaten_cnt[idx] != {COUNT_BITS{1'b1}}) begin
                  s = {1'b0, dly_sum[idx]} + delay;
                  dly_sum[idx] = s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
                  eaten_cnt[idx]++;
               end
            end
         end
         unequal = 0;
         for (int i = 0; i < lim; i++)
            if (made_cnt[i] != eaten_cnt[i]) unequal++;

         r.entry_index  = idx;
         r.any_mismatch = unequal != 0;
         r.bad_index    = bad;
         if (bad) begin
            r.made_count     = '0;
            r.eaten_count    = '0;
            r.shortest_delay = '0;
            r.mean_delay     = '0;
            r.longest_delay  = '0;
            r.entry_mismatch = 1'b0;
         end else begin
            r.made_count     = made_cnt[idx];
            r.eaten_count    = eaten_cnt[idx];
            r.entry_mismatch = made_cnt[idx] != eaten_cnt[idx];
            if (eaten_cnt[idx] == 0) begin
               r.shortest_delay = '0;
               r.mean_delay     = '0;
               r.longest_delay  = '0;
            end else begin
               q = dly_sum[idx] / eaten_cnt[idx];
               r.shortest_delay = min_dly[idx];
               r.longest_delay  = max_dly[idx];
               r.mean_delay = (q > {DELAY_BITS{1'b1}}) ? {DELAY_BITS{1'b1}} : q[DELAY_BITS-1:0];
            end
         end
         expected_reports.push_back(r);
      endfunction

      function void check_field(string name, logic [47:0] want, logic [47:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_report(stats_report_type got);
         stats_report_type want;
         if (expected_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, expected none, actual entry %0h",
                     $time, got.entry_index);
            return;
         end
         want = expected_reports.pop_front();
         check_field("entry_index", want.entry_index, got.entry_index);
         check_field("made_count", want.made_count, got.made_count);
         check_field("eaten_count", want.eaten_count, got.eaten_count);
         check_field("shortest_delay", want.shortest_delay, got.shortest_delay);
         check_field("mean_delay", want.mean_delay, got.mean_delay);
         check_field("longest_delay", want.longest_delay, got.longest_delay);
         check_field("entry_mismatch", want.entry_mismatch, got.entry_mismatch);
         check_field("any_mismatch", want.any_mismatch, got.any_mismatch);
         check_field("bad_index", want.bad_index, got.bad_index);
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [KIND_BITS-1:0]     req_type = KIND_READ;
   logic [IDX_BITS-1:0]      req_producer_index = '0;
   logic [DELAY_BITS-1:0]    req_delay_ms = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [IDX_BITS-1:0]      rsp_entry_index;
   logic [COUNT_BITS-1:0]    rsp_made_count;
   logic [COUNT_BITS-1:0]    rsp_eaten_count;
   logic [DELAY_BITS-1:0]    rsp_shortest_delay;
   logic [DELAY_BITS-1:0]    rsp_mean_delay;
   logic [DELAY_BITS-1:0]    rsp_longest_delay;
   logic                     rsp_entry_mismatch;
   logic                     rsp_any_mismatch;
   logic                     rsp_bad_index;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   latency_stats_scoreboard stats = new();
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int cur_limit = MAX_PRODUCERS;

   per_source_latency_stats_table_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_producer_index (req_producer_index),
      .req_delay_ms       (req_delay_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_made_count     (rsp_made_count),
      .rsp_eaten_count    (rsp_eaten_count),
      .rsp_shortest_delay (rsp_shortest_delay),
      .rsp_mean_delay     (rsp_mean_delay),
      .rsp_longest_delay  (rsp_longest_delay),
      .rsp_entry_mismatch (rsp_entry_mismatch),
      .rsp_any_mismatch   (rsp_any_mismatch),
      .rsp_bad_index      (rsp_bad_index),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // receiver stall: modes of none, light, heavy and long periodic stalls
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(64, 512);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((stall_left % 64) < 40);
      endcase
   end

   always @(posedge clock) begin
      stats_report_type got;
      bit               moved;
      moved = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         stats.record_request(req_type, req_producer_index, req_delay_ms);
         moved = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got.entry_index    = rsp_entry_index;
         got.made_count     = rsp_made_count;
         got.eaten_count    = rsp_eaten_count;
         got.shortest_delay = rsp_shortest_delay;
         got.mean_delay     = rsp_mean_delay;
         got.longest_delay  = rsp_longest_delay;
         got.entry_mismatch = rsp_entry_mismatch;
         got.any_mismatch   = rsp_any_mismatch;
         got.bad_index      = rsp_bad_index;
         stats.check_report(got);
         moved = 1'b1;
      end
      if (csr_psel && csr_penable && csr_pready) moved = 1'b1;
      idle_cycles <= moved ? 0 : idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("FAIL per_source_latency_stats_table_top");
      $finish;
   end

   task automatic send_request(bit [KIND_BITS-1:0] kind, bit [IDX_BITS-1:0] idx,
                               bit [DELAY_BITS-1:0] delay);
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_producer_index <= idx;
      req_delay_ms       <= delay;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      pause_sender(1);
      while (stats.pending() != 0) @(posedge clock);
      repeat (RESULT_LATENCY) @(posedge clock);
   endtask

   // write active_producers, then read it back
   task automatic write_active_producers(bit [LIMIT_BITS-1:0] value);
      bit [CSR_DATA_BITS-1:0] wdata;
      wdata = $urandom;
      wdata[LIMIT_BITS-1:0] = value;
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ACTIVE_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      stats.set_active(value);
      cur_limit = (value < MAX_PRODUCERS) ? value : MAX_PRODUCERS;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== CSR_DATA_BITS'(value)) begin
         stats.errors++;
         $display("%0t: active_producers readback mismatch, expected %0h, actual %0h",
                  $time, value, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_request();
      bit [KIND_BITS-1:0]  kind;
      bit [IDX_BITS-1:0]   idx;
      bit [DELAY_BITS-1:0] delay;
      int                  pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      kind = KIND_MADE;
      else if (pick < 80) kind = KIND_EATEN;
      else if (pick < 94) kind = KIND_READ;
      else                kind = KIND_UNKNOWN;
      if (cur_limit > 0 && $urandom_range(0, 9) != 0)
         idx = $urandom_range(0, cur_limit - 1);
      else
         idx = $urandom_range(0, MAX_PRODUCERS - 1);
      case ($urandom_range(0, 9))
         0:       delay = '0;
         1:       delay = '1;
         2, 3:    delay = $urandom;
         4, 5, 6: delay = $urandom_range(0, 4095);
         default: delay = $urandom_range(24'h001000, 24'h040000);
      endcase
      send_request(kind, idx, delay);
   endtask

   initial begin
      int left;
      int burst;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty entry, first sample of zero, extremes, min/max tracking, made counts, unknown kind
      send_request(KIND_READ, 4'd0, 24'd0);
      send_request(KIND_EATEN, 4'd0, 24'd0);
      send_request(KIND_EATEN, 4'd0, 24'hFFFFFF);
      send_request(KIND_EATEN, 4'd0, 24'h000100);
      send_request(KIND_MADE, 4'd0, 24'd0);
      send_request(KIND_MADE, 4'd0, 24'd0);
      send_request(KIND_UNKNOWN, 4'd0, 24'hAAAAAA);
      send_request(KIND_EATEN, 4'd15, 24'hFFFFFF);
      send_request(KIND_EATEN, 4'd15, 24'h000001);
      send_request(KIND_MADE, 4'd15, 24'd0);
      send_request(KIND_EATEN, 4'd10, 24'h555555);
      send_request(KIND_MADE, 4'd5, 24'd0);
      send_request(KIND_READ, 4'd5, 24'd0);

      write_active_producers(5'd5);
      send_request(KIND_READ, 4'd15, 24'd0);
      send_request(KIND_MADE, 4'd4, 24'd0);
      send_request(KIND_EATEN, 4'd5, 24'h000010);

      write_active_producers(5'd0);
      send_request(KIND_READ, 4'd0, 24'd0);
      send_request(KIND_EATEN, 4'd0, 24'h000020);

      write_active_producers(5'd31);
      send_request(KIND_READ, 4'd15, 24'd0);
      send_request(KIND_MADE, 4'd15, 24'd0);

      write_active_producers(5'd1);
      send_request(KIND_EATEN, 4'd0, 24'h123456);
      send_request(KIND_MADE, 4'd1, 24'd0);

      left = RANDOM_ITEMS;
      while (left > 0) begin
         if (left % PHASE_ITEMS == 0) begin
            case ($urandom_range(0, 5))
               0:       write_active_producers(5'd16);
               1:       write_active_producers(5'd31);
               2:       write_active_producers(5'd1);
               4:       write_active_producers(5'($urandom_range(17, 30)));
               default: write_active_producers(5'($urandom_range(2, 15)));
            endcase
         end else if (left % PHASE_ITEMS == PHASE_ITEMS / 2) begin
            wait_idle();
         end
         burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
         while (burst > 0 && left > 0) begin
            send_random_request();
            burst--;
            left--;
            if (left % PHASE_ITEMS == 0 || left % PHASE_ITEMS == PHASE_ITEMS / 2) burst = 0;
         end
         pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
      end

      wait_idle();
      if (stats.errors == 0 && stats.pending() == 0)
         $display("PASS per_source_latency_stats_table_top");
      else
         $display("FAIL per_source_latency_stats_table_top");
      $finish;
   end

endmodule
